// ===== rtl/kfbi_pkg.sv =====
// Package for the five-baud slow-init handshake: phase, action and register codes, constants.
package kfbi_pkg;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_START    = 3'd1,
        PH_DATA     = 3'd2,
        PH_PARITY   = 3'd3,
        PH_KEYWORD  = 3'd4,
        PH_GUARD    = 3'd5,
        PH_LOOPBACK = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_BYTE  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        REG_TARGET_ADDRESS  = 3'd0,
        REG_DATA_BITS       = 3'd1,
        REG_PARITY_MODE     = 3'd2,
        REG_BIT_PERIOD      = 3'd3,
        REG_KEYWORD_COUNT   = 3'd4,
        REG_ECHO_INDEX      = 3'd5,
        REG_ECHO_INVERTED   = 3'd6,
        REG_KEYWORD_TIMEOUT = 3'd7
    } cfg_index_t;

    localparam logic [1:0] PARITY_ODD  = 2'd1;
    localparam logic [1:0] PARITY_EVEN = 2'd2;

    localparam logic [3:0]  MAX_KEYWORD_BYTES  = 4'd8;
    localparam logic [15:0] ECHO_TIMEOUT_TICKS = 16'd1000;
    localparam logic [15:0] GUARD_TICKS        = 16'd5;
    localparam logic [15:0] TICK_MAX           = 16'hFFFF;
    localparam logic [7:0]  SYNC_BYTE          = 8'h55;

    // One result item.
    typedef struct packed {
        logic       success;
        logic       done_res;
        logic       busy_res;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       line_level;
    } result_t;

endpackage

// ===== rtl/kline_five_baud_init_handshake.sv =====
// Five-baud slow-init handshake controller with stream input, stream output and register port.
//
// Input channel (s_axis_*): one transfer per event. tuser carries the action
// (start, one tick elapsed, byte received) and tdata the received byte.
// Output channel (m_axis_*): exactly one result transfer per input transfer, in order, giving
// line level, echo request and byte, busy, done and success. Registers are written through
// cfg_we/cfg_index/cfg_data; the user must write only while the block idles (not enforced).
//
// An accepted item lands in an input register; once the result register is free or being
// taken, the state machine evaluates it in one pass and loads the state and the result
// register together. Throughput is one item per cycle while the receiver takes every result,
// set by the single-pass state update.
// The input register and the result register decouple the two sides: while the
// receiver stalls, at most one further item is still taken into the input register, and
// then tready falls until the result is taken.
// Reset empties both registers, puts the handshake into its idle phase and loads
// the register defaults.
module kline_five_baud_init_handshake (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] line_level, [1] tx_valid, [9:2] tx_byte, [10] busy_res, [11] done_res,
    // [12] success, [15:13] zero
    output logic [15:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers.
    logic [7:0]  target_address_reg;
    logic [3:0]  data_bits_reg;
    logic [1:0]  parity_mode_reg;
    logic [15:0] bit_period_reg;
    logic [3:0]  keyword_count_reg;
    logic [3:0]  echo_index_reg;
    logic        echo_inverted_reg;
    logic [15:0] keyword_timeout_reg;

    // Pipeline registers.
    logic        in_valid_reg;
    logic [1:0]  in_action_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    kfbi_pkg::result_t out_reg;

    // Handshake state.
    kfbi_pkg::phase_t phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [3:0]  bitpos_reg, bitpos_next;
    logic        parity_reg, parity_next;
    logic [3:0]  matched_reg, matched_next;
    logic [7:0]  cand_reg, cand_next;

    logic        ev_finish, ev_ok, ev_echo;
    kfbi_pkg::result_t result_next;

    logic        advance;
    logic        in_accept;
    logic [15:0] tick_inc;
    logic [15:0] period;
    logic        period_over;
    logic [3:0]  eff_count;
    logic        echo_skip;
    logic        cur_data_bit;
    logic [3:0]  bitpos_inc;
    logic [3:0]  matched_inc;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_address_reg  <= 8'd0;
            data_bits_reg       <= 4'd7;
            parity_mode_reg     <= kfbi_pkg::PARITY_ODD;
            bit_period_reg      <= 16'd200;
            keyword_count_reg   <= 4'd3;
            echo_index_reg      <= 4'd2;
            echo_inverted_reg   <= 1'b1;
            keyword_timeout_reg <= 16'd1500;
        end
        else if (cfg_we)
        begin
            unique case (kfbi_pkg::cfg_index_t'(cfg_index))
                kfbi_pkg::REG_TARGET_ADDRESS:  target_address_reg  <= cfg_data[7:0];
                kfbi_pkg::REG_DATA_BITS:       data_bits_reg       <= cfg_data[3:0];
                kfbi_pkg::REG_PARITY_MODE:     parity_mode_reg     <= cfg_data[1:0];
                kfbi_pkg::REG_BIT_PERIOD:      bit_period_reg      <= cfg_data;
                kfbi_pkg::REG_KEYWORD_COUNT:   keyword_count_reg   <= cfg_data[3:0];
                kfbi_pkg::REG_ECHO_INDEX:      echo_index_reg      <= cfg_data[3:0];
                kfbi_pkg::REG_ECHO_INVERTED:   echo_inverted_reg   <= cfg_data[0];
                kfbi_pkg::REG_KEYWORD_TIMEOUT: keyword_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_action_reg <= s_axis_tuser;
            in_byte_reg   <= s_axis_tdata;
        end
    end

    // State and result register load only on evaluation; the valid bit drops once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= kfbi_pkg::PH_IDLE;
            tick_reg      <= 16'd0;
            bitpos_reg    <= 4'd0;
            parity_reg    <= 1'b0;
            matched_reg   <= 4'd0;
            cand_reg      <= 8'd0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            bitpos_reg    <= bitpos_next;
            parity_reg    <= parity_next;
            matched_reg   <= matched_next;
            cand_reg      <= cand_next;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    // Shared terms of the state update.
    assign tick_inc    = (tick_reg == kfbi_pkg::TICK_MAX) ? tick_reg : tick_reg + 16'd1;
    assign period      = (bit_period_reg == 16'd0) ? 16'd1 : bit_period_reg;
    assign period_over = (tick_inc >= period);
    assign eff_count   = (keyword_count_reg > kfbi_pkg::MAX_KEYWORD_BYTES) ?
                         kfbi_pkg::MAX_KEYWORD_BYTES : keyword_count_reg;
    // A negative echo index, or one beyond the collected keywords, means no echo.
    assign echo_skip   = echo_index_reg[3] || (echo_index_reg >= eff_count);
    assign cur_data_bit = bitpos_reg[3] ? 1'b0 : target_address_reg[bitpos_reg[2:0]];
    assign bitpos_inc  = bitpos_reg + 4'd1;
    assign matched_inc = matched_reg + 4'd1;

    // Next state.
    always_comb
    begin
        logic after_data;
        logic go_stop;
        logic go_complete;

        after_data   = 1'b0;
        go_stop      = 1'b0;
        go_complete  = 1'b0;
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bitpos_next  = bitpos_reg;
        parity_next  = parity_reg;
        matched_next = matched_reg;
        cand_next    = cand_reg;
        ev_finish    = 1'b0;
        ev_ok        = 1'b0;
        ev_echo      = 1'b0;

        unique case (kfbi_pkg::action_t'(in_action_reg))
            kfbi_pkg::ACT_START:
            begin
                // A start while the handshake runs is ignored.
                if (phase_reg == kfbi_pkg::PH_IDLE)
                begin
                    phase_next   = kfbi_pkg::PH_START;
                    tick_next    = 16'd0;
                    bitpos_next  = 4'd0;
                    parity_next  = 1'b0;
                    matched_next = 4'd0;
                    cand_next    = 8'd0;
                end
            end
            kfbi_pkg::ACT_TICK:
            begin
                unique case (phase_reg)
                    kfbi_pkg::PH_START:
                    begin
                        if (period_over)
                        begin
                            tick_next   = 16'd0;
                            bitpos_next = 4'd0;
                            if (data_bits_reg == 4'd0)
                            begin
                                after_data = 1'b1;
                            end
                            else
                            begin
                                phase_next = kfbi_pkg::PH_DATA;
                            end
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                    kfbi_pkg::PH_DATA:
                    begin
                        if (period_over)
                        begin
                            tick_next   = 16'd0;
                            parity_next = parity_reg ^ cur_data_bit;
                            bitpos_next = bitpos_inc;
                            if (bitpos_inc == 4'd0 || bitpos_inc >= data_bits_reg)
                            begin
                                after_data = 1'b1;
                            end
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                    kfbi_pkg::PH_PARITY:
                    begin
                        if (period_over)
                        begin
                            go_stop = 1'b1;
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                    kfbi_pkg::PH_KEYWORD:
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= keyword_timeout_reg)
                        begin
                            ev_finish = 1'b1;
                        end
                    end
                    kfbi_pkg::PH_GUARD:
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= kfbi_pkg::GUARD_TICKS)
                        begin
                            ev_echo    = 1'b1;
                            phase_next = kfbi_pkg::PH_LOOPBACK;
                            tick_next  = 16'd0;
                        end
                    end
                    kfbi_pkg::PH_LOOPBACK:
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= kfbi_pkg::ECHO_TIMEOUT_TICKS)
                        begin
                            ev_finish = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            kfbi_pkg::ACT_BYTE:
            begin
                if (phase_reg == kfbi_pkg::PH_KEYWORD)
                begin
                    // Bytes before the sync byte are dropped.
                    if (matched_reg != 4'd0 || in_byte_reg == kfbi_pkg::SYNC_BYTE)
                    begin
                        if (!echo_index_reg[3] && matched_reg == echo_index_reg)
                        begin
                            cand_next = in_byte_reg;
                        end
                        matched_next = matched_inc;
                        if (matched_inc >= eff_count)
                        begin
                            go_complete = 1'b1;
                        end
                    end
                end
                else if (phase_reg == kfbi_pkg::PH_LOOPBACK)
                begin
                    ev_finish = 1'b1;
                    ev_ok     = 1'b1;
                end
            end
            default: ;
        endcase

        if (after_data)
        begin
            tick_next = 16'd0;
            if (parity_mode_reg == kfbi_pkg::PARITY_ODD ||
                parity_mode_reg == kfbi_pkg::PARITY_EVEN)
            begin
                phase_next = kfbi_pkg::PH_PARITY;
            end
            else
            begin
                go_stop = 1'b1;
            end
        end

        // The stop bit releases the line and keyword collection begins at once.
        if (go_stop)
        begin
            phase_next   = kfbi_pkg::PH_KEYWORD;
            tick_next    = 16'd0;
            matched_next = 4'd0;
            if (eff_count == 4'd0)
            begin
                go_complete = 1'b1;
            end
        end

        if (go_complete)
        begin
            if (echo_skip)
            begin
                ev_finish = 1'b1;
                ev_ok     = 1'b1;
            end
            else
            begin
                phase_next = kfbi_pkg::PH_GUARD;
                tick_next  = 16'd0;
            end
        end

        if (ev_finish)
        begin
            phase_next = kfbi_pkg::PH_IDLE;
            tick_next  = 16'd0;
        end
    end

    // Result fields, taken from the state after the item.
    always_comb
    begin
        result_next = '0;
        unique case (phase_next)
            kfbi_pkg::PH_START:  result_next.line_level = 1'b0;
            kfbi_pkg::PH_DATA:   result_next.line_level =
                                     bitpos_next[3] ? 1'b0 :
                                     target_address_reg[bitpos_next[2:0]];
            kfbi_pkg::PH_PARITY: result_next.line_level =
                                     (parity_mode_reg == kfbi_pkg::PARITY_EVEN) ?
                                     parity_next : !parity_next;
            default:             result_next.line_level = 1'b1;
        endcase
        result_next.tx_valid = ev_echo;
        if (ev_echo)
        begin
            result_next.tx_byte = echo_inverted_reg ? ~cand_reg : cand_reg;
        end
        result_next.busy_res = (phase_next != kfbi_pkg::PH_IDLE);
        result_next.done_res = ev_finish;
        result_next.success  = ev_ok;
    end

`ifndef SYNTH
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.done_res) |-> !out_reg.busy_res)
        else $error("finished handshake reported as busy");

    a_echo_enters_loopback: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.tx_valid) |-> (phase_reg == kfbi_pkg::PH_LOOPBACK))
        else $error("echo byte sent without entering loopback wait");

    a_idle_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == kfbi_pkg::PH_IDLE) |-> (tick_reg == 16'd0))
        else $error("tick counter not cleared while idle");

    a_success_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (!out_reg.success || out_reg.done_res))
        else $error("success flagged on an item that does not finish");
`endif

endmodule
